>>> hdl/flic_chunk_pixel_decoder_top_assert.svh
// Assertion macros shared by the decoder modules.
// Needs signals clk and arst_n in the scope of use.
`ifndef FLIC_CHUNK_PIXEL_DECODER_TOP_ASSERT_SVH
`define FLIC_CHUNK_PIXEL_DECODER_TOP_ASSERT_SVH
// condition holds at every edge out of reset
`define FLIC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("flic assertion failed");
// antecedent implies consequent in the next cycle
`define FLIC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flic assertion failed");
`endif

>>> hdl/flic_pkg.sv
// Shared types and constants of the chunk pixel decoder.
// No dependencies.
package flic_pkg;
	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
	localparam logic [CNT_W-1:0] RESET_WIDTH = 11'd320;
	localparam logic [CNT_W-1:0] RESET_HEIGHT = 11'd200;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int ADDR_W = 3;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE, PH_BPKT, PH_COUNT, PH_REP_LO, PH_REP_HI, PH_LIT_LO, PH_LIT_HI,
		PH_LINES_LO, PH_LINES_HI, PH_WORD_LO, PH_WORD_HI, PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] width;
		logic [CNT_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic [15:0] value;
		logic [7:0] len;
		logic marker;
		logic last;
	} cmd_t;

	function automatic logic [CNT_W-1:0] eff(input logic [CNT_W-1:0] v);
		return (v == '0) ? CNT_W'(1) : v;
	endfunction
endpackage

>>> hdl/flic_front.sv
// Byte parser: walks the chunk grammar and issues fill commands.
// Uses flic_pkg.
module flic_front import flic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	input  logic [7:0] data_byte,
	input  logic chunk_start,
	input  logic chunk_kind,
	output logic wr,
	output cmd_t cmd
);
	typedef struct packed {
		phase_t ph;
		logic k;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic [15:0] lines;
		logic [15:0] pk;
		logic [7:0] rc;
		logic [7:0] ll;
		logic [7:0] lo;
	} st_t;

	st_t st_q, nx;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [16:0] b);
		logic [17:0] s;
		s = {7'd0, a} + {1'b0, b};
		return (s > {7'd0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	always_comb begin
		st_t s;
		logic done, emit, fin, neg;
		logic [7:0] mag, flen;
		logic [15:0] word;
		logic [CNT_W-1:0] w, h;
		s = st_q;
		done = 1'b0;
		emit = 1'b0;
		fin = 1'b0;
		flen = 8'd0;
		word = {data_byte, st_q.lo};
		w = eff(cfg.width);
		h = eff(cfg.height);
		neg = data_byte[7];
		mag = neg ? (8'd0 - data_byte) : data_byte;
		cmd = '0;
		if (chunk_start) begin
			s = '0;
			s.k = chunk_kind;
			s.ph = chunk_kind ? PH_LINES_LO : PH_BPKT;
		end
		word = {data_byte, s.lo};
		case (s.ph)
			PH_BPKT: s.ph = PH_COUNT;
			PH_COUNT: begin
				if (mag == 8'd0) begin
					fin = 1'b1;
				end else if (neg == s.k) begin
					s.rc = mag;
					s.ph = PH_REP_LO;
				end else begin
					s.ll = mag;
					s.ph = PH_LIT_LO;
				end
			end
			PH_REP_LO: begin
				s.lo = data_byte;
				s.ph = PH_REP_HI;
			end
			PH_LIT_LO: begin
				s.lo = data_byte;
				s.ph = PH_LIT_HI;
			end
			PH_REP_HI: begin
				emit = 1'b1;
				flen = s.rc;
				fin = 1'b1;
			end
			PH_LIT_HI: begin
				emit = 1'b1;
				flen = 8'd1;
				s.ll = s.ll - 8'd1;
				if (s.ll == 8'd0) fin = 1'b1;
				else s.ph = PH_LIT_LO;
			end
			PH_LINES_LO: begin
				s.lo = data_byte;
				s.ph = PH_LINES_HI;
			end
			PH_LINES_HI: begin
				s.lines = word;
				if (word == 16'd0) begin
					s.ph = PH_IDLE;
					done = 1'b1;
				end else begin
					s.ph = PH_WORD_LO;
				end
			end
			PH_WORD_LO: begin
				s.lo = data_byte;
				s.ph = PH_WORD_HI;
			end
			PH_WORD_HI: begin
				if (word[15]) begin
					s.row = sat_add(s.row, 17'h10000 - {1'b0, word});
					s.ph = PH_WORD_LO;
				end else if (word == 16'd0) begin
					// empty line: same as the last packet of a line
					s.pk = 16'd1;
					fin = 1'b1;
				end else begin
					s.pk = word;
					s.col = '0;
					s.ph = PH_SKIP;
				end
			end
			PH_SKIP: begin
				s.col = sat_add(s.col, {9'd0, data_byte});
				s.ph = PH_COUNT;
			end
			default: s.ph = PH_IDLE;
		endcase
		if (emit) begin
			cmd.row = s.row;
			cmd.col = s.col;
			cmd.value = word;
			cmd.len = flen;
			s.col = sat_add(s.col, {9'd0, flen});
		end
		if (fin) begin
			if (!s.k) begin
				if (s.col >= w) begin
					s.col = '0;
					s.row = sat_add(s.row, 17'd1);
					if (s.row >= h) begin
						s.ph = PH_IDLE;
						done = 1'b1;
					end else begin
						s.ph = PH_BPKT;
					end
				end else begin
					s.ph = PH_COUNT;
				end
			end else begin
				s.pk = s.pk - 16'd1;
				if (s.pk == 16'd0) begin
					s.row = sat_add(s.row, 17'd1);
					s.lines = s.lines - 16'd1;
					if (s.lines == 16'd0) begin
						s.ph = PH_IDLE;
						done = 1'b1;
					end else begin
						s.ph = PH_WORD_LO;
					end
				end else begin
					s.ph = PH_SKIP;
				end
			end
		end
		cmd.marker = done && !emit;
		cmd.last = done;
		wr = in_valid && (emit || done);
		nx = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_valid) begin
			st_q <= nx;
		end
	end
endmodule

>>> hdl/flic_fifo.sv
// Short command queue between parser and index stage.
// Uses flic_pkg and the assertion macro header.
`include "flic_chunk_pixel_decoder_top_assert.svh"
module flic_fifo import flic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic full,
	output logic empty
);
	cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

	`FLIC_ASSERT(a_no_overflow, !(wr && full && !rd))
	`FLIC_ASSERT(a_no_underflow, !(rd && empty))
	`FLIC_ASSERT_NEXT(a_count_up, wr && !rd, count_q == $past(count_q) + 1'b1)
endmodule

>>> hdl/flic_back.sv
// Index stage: multiplies out the bottom-up pixel address and frame check.
// Uses flic_pkg and the assertion macro header.
`include "flic_chunk_pixel_decoder_top_assert.svh"
module flic_back import flic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	input  cmd_t q_data,
	output logic q_rd,
	input  logic pop,
	output logic empty,
	output logic [19:0] pixel_index,
	output logic [15:0] pixel_value,
	output logic [7:0] run_length,
	output logic out_of_frame,
	output logic chunk_end
);
	logic [CNT_W-1:0] w, h;
	logic [21:0] wh_q;
	logic v_s1, v_s2, adv_s1, adv_s2;
	cmd_t cmd_s1;
	logic signed [24:0] prod_s1;
	logic signed [12:0] diff;
	logic signed [25:0] idx;
	logic signed [26:0] idx_end;

	assign w = eff(cfg.width);
	assign h = eff(cfg.height);
	assign diff = $signed({2'b00, h}) - $signed({2'b00, q_data.row}) - 13'sd1;
	assign adv_s2 = !v_s2 || pop;
	assign adv_s1 = !v_s1 || adv_s2;
	assign q_rd = adv_s1 && !q_empty;
	assign idx = 26'(prod_s1) + $signed({15'd0, cmd_s1.col});
	assign idx_end = 27'(idx) + $signed({19'd0, cmd_s1.len});
	assign empty = !v_s2;

	always_ff @(posedge clk) begin
		wh_q <= w * h;
		if (adv_s1 && !q_empty) begin
			cmd_s1 <= q_data;
			prod_s1 <= diff * $signed({1'b0, w});
		end
		if (adv_s2 && v_s1) begin
			chunk_end <= cmd_s1.last;
			if (cmd_s1.marker) begin
				pixel_index <= '0;
				pixel_value <= '0;
				run_length <= '0;
				out_of_frame <= 1'b0;
			end else begin
				pixel_index <= idx[19:0];
				pixel_value <= cmd_s1.value;
				run_length <= cmd_s1.len;
				out_of_frame <= idx[25] || (idx_end > $signed({5'd0, wh_q}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= !q_empty;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	`FLIC_ASSERT_NEXT(a_hold_stall, v_s2 && !pop, v_s2 && $stable(pixel_index))
	`FLIC_ASSERT(a_no_read_busy, !(q_rd && v_s1 && v_s2 && !pop))
	`FLIC_ASSERT_NEXT(a_s1_moves, v_s1 && adv_s2, v_s2)
endmodule

>>> hdl/flic_chunk_pixel_decoder_top.sv
// Channel   | handshake           | payload
// input     | push / full         | data_byte, chunk_start, chunk_kind
// result    | pop / empty         | pixel_index, pixel_value, run_length, out_of_frame, chunk_end
// config    | APB psel/penable    | frame_width @0x0, frame_height @0x4
// One byte accepted per cycle while full is low; a result passes through the command queue
// and the index stages before it reaches the ports.
// The parser updates its counters as each byte is accepted; the index multiply
// and frame check take two pipeline stages behind a four-entry command queue.
// full rises only when that queue fills while results are not popped.
// Asynchronous reset: parser idle, queue and pipeline empty, 320 x 200 frame.
// Top level: config registers, parser, queue and index stage. Uses flic_pkg.
module flic_chunk_pixel_decoder_top import flic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic [7:0] data_byte,
	input  logic chunk_start,
	input  logic chunk_kind,
	input  logic pop,
	output logic empty,
	output logic [19:0] pixel_index,
	output logic [15:0] pixel_value,
	output logic [7:0] run_length,
	output logic out_of_frame,
	output logic chunk_end
);
	cfg_t cfg_q;
	logic wr, q_rd, q_empty;
	cmd_t wcmd, qcmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {21'd0, cfg_q.height} : {21'd0, cfg_q.width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= RESET_WIDTH;
			cfg_q.height <= RESET_HEIGHT;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) cfg_q.width <= pwdata[CNT_W-1:0];
			else cfg_q.height <= pwdata[CNT_W-1:0];
		end
	end

	flic_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_valid(push && !full),
		.data_byte(data_byte), .chunk_start(chunk_start), .chunk_kind(chunk_kind),
		.wr(wr), .cmd(wcmd)
	);

	flic_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wdata(wcmd), .rd(q_rd),
		.rdata(qcmd), .full(full), .empty(q_empty)
	);

	flic_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(q_empty), .q_data(qcmd),
		.q_rd(q_rd), .pop(pop), .empty(empty), .pixel_index(pixel_index),
		.pixel_value(pixel_value), .run_length(run_length),
		.out_of_frame(out_of_frame), .chunk_end(chunk_end)
	);
endmodule

>>> tb/tb_top.sv
// Testbench for flic_chunk_pixel_decoder_top: byte streams of run and delta chunks
// against a built-in decoder model, results checked in order. Uses flic_pkg.
`timescale 1ns / 100ps
module tb_top import flic_pkg::*; ();

	typedef struct {
		logic [19:0] idx;
		logic [15:0] val;
		logic [7:0] len;
		logic oof;
		logic last;
	} fill_cmd_t;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 0, full;
	logic [7:0] data_byte = '0;
	logic chunk_start = 0, chunk_kind = 0;
	logic pop = 0, empty;
	logic [19:0] pixel_index;
	logic [15:0] pixel_value;
	logic [7:0] run_length;
	logic out_of_frame, chunk_end;

	flic_chunk_pixel_decoder_top dut (.*);

	// decoder model state
	int cfg_w = 320, cfg_h = 200;
	phase_t phase = PH_IDLE;
	bit kind_lc;
	int row, col, lines_left, packets_left, rep_len, lit_left;
	logic [7:0] lo_byte;

	fill_cmd_t fill_q[$];
	int errors = 0, items_sent = 0, cycles = 0;
	bit calm = 0;

	initial forever #2 clk = ~clk;

	function automatic int sat11(input int v);
		return v > 2047 ? 2047 : v;
	endfunction

	function automatic fill_cmd_t make_fill(input logic [15:0] v, input int len);
		fill_cmd_t c;
		longint w, h, idx;
		w = cfg_w == 0 ? 1 : cfg_w;
		h = cfg_h == 0 ? 1 : cfg_h;
		idx = (h - row - 1) * w + col;
		c.idx = idx[19:0];
		c.val = v;
		c.len = len[7:0];
		c.oof = (idx < 0) || (idx + len > w * h);
		c.last = 0;
		col = sat11(col + len);
		return c;
	endfunction

	function automatic bit end_lc_line();
		row = sat11(row + 1);
		lines_left = (lines_left - 1) & 16'hFFFF;
		if (lines_left == 0) begin
			phase = PH_IDLE;
			return 1;
		end
		phase = PH_WORD_LO;
		return 0;
	endfunction

	function automatic bit finish_packet();
		int w, h;
		w = cfg_w == 0 ? 1 : cfg_w;
		h = cfg_h == 0 ? 1 : cfg_h;
		if (!kind_lc) begin
			if (col >= w) begin
				col = 0;
				row = sat11(row + 1);
				if (row >= h) begin
					phase = PH_IDLE;
					return 1;
				end
				phase = PH_BPKT;
			end else
				phase = PH_COUNT;
			return 0;
		end
		packets_left = (packets_left - 1) & 16'hFFFF;
		if (packets_left == 0)
			return end_lc_line();
		phase = PH_SKIP;
		return 0;
	endfunction

	// one accepted byte; returns 1 when it yields a fill command
	function automatic bit decode_byte(input logic [7:0] b, input bit st, input bit kd,
			output fill_cmd_t c);
		bit done = 0, emitted = 0, neg;
		int mag, word;
		c = '{default: 0};
		if (st) begin
			kind_lc = kd;
			row = 0; col = 0; lines_left = 0; packets_left = 0;
			rep_len = 0; lit_left = 0; lo_byte = 0;
			phase = kd ? PH_LINES_LO : PH_BPKT;
		end
		case (phase)
			PH_BPKT: phase = PH_COUNT;
			PH_COUNT: begin
				neg = b[7];
				mag = neg ? 256 - b : b;
				if (mag == 0)
					done = finish_packet();
				else if (neg == kind_lc) begin
					rep_len = mag;
					phase = PH_REP_LO;
				end else begin
					lit_left = mag;
					phase = PH_LIT_LO;
				end
			end
			PH_REP_LO, PH_LIT_LO: begin
				lo_byte = b;
				phase = phase == PH_REP_LO ? PH_REP_HI : PH_LIT_HI;
			end
			PH_REP_HI: begin
				emitted = 1;
				c = make_fill({b, lo_byte}, rep_len);
				done = finish_packet();
			end
			PH_LIT_HI: begin
				emitted = 1;
				c = make_fill({b, lo_byte}, 1);
				lit_left = (lit_left - 1) & 8'hFF;
				if (lit_left == 0)
					done = finish_packet();
				else
					phase = PH_LIT_LO;
			end
			PH_LINES_LO: begin
				lo_byte = b;
				phase = PH_LINES_HI;
			end
			PH_LINES_HI: begin
				lines_left = {b, lo_byte};
				if (lines_left == 0) begin
					phase = PH_IDLE;
					done = 1;
				end else
					phase = PH_WORD_LO;
			end
			PH_WORD_LO: begin
				lo_byte = b;
				phase = PH_WORD_HI;
			end
			PH_WORD_HI: begin
				word = {b, lo_byte};
				if (word[15]) begin
					row = sat11(row + (65536 - word));
					phase = PH_WORD_LO;
				end else if (word == 0)
					done = end_lc_line();
				else begin
					packets_left = word;
					col = 0;
					phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				col = sat11(col + b);
				phase = PH_COUNT;
			end
			default: phase = PH_IDLE;
		endcase
		if (done)
			c.last = 1;
		return done || emitted;
	endfunction

	// sends one item; called at a falling edge, returns at a falling edge with push high
	task automatic send_byte(input logic [7:0] b, input bit st = 0, input bit kd = 0);
		fill_cmd_t c;
		if (!calm && $urandom_range(0, 9) == 0) begin
			push = 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		push = 1;
		data_byte = b;
		chunk_start = st;
		chunk_kind = kd;
		do @(posedge clk); while (full);
		if (decode_byte(b, st, kd, c))
			fill_q.insert(fill_q.size(), c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixel();
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		push = 0;
		wait (fill_q.size() == 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input int val);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {sel, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		if (sel == REG_WIDTH)
			cfg_w = val & 11'h7FF;
		else
			cfg_h = val & 11'h7FF;
	endtask

	task automatic set_frame(input int w, input int h);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// well-formed run chunk; may stop early when cut is set
	task automatic brun_chunk(input bit cut);
		int w, h, x, n, r;
		w = cfg_w == 0 ? 1 : cfg_w;
		h = cfg_h == 0 ? 1 : cfg_h;
		for (int line = 0; line < h; line++) begin
			send_byte(8'($urandom_range(0, 255)), line == 0, 0);
			x = 0;
			while (x < w) begin
				if (cut && $urandom_range(0, 59) == 0)
					return;
				r = $urandom_range(0, 9);
				if (r < 4) begin
					n = $urandom_range(1, r == 0 ? 127 : 8);
					send_byte(8'(n));
					send_pixel();
				end else if (r < 9) begin
					n = $urandom_range(1, r == 8 && $urandom_range(0, 7) == 0 ? 128 : 4);
					send_byte(8'(256 - n));
					repeat (n) send_pixel();
				end else begin
					n = 0;
					send_byte(0);
				end
				x += n;
			end
		end
	endtask

	// well-formed delta chunk with the given line count
	task automatic lc_chunk(input int lines, input bit cut);
		int w, p, n, r, sk;
		w = cfg_w == 0 ? 1 : cfg_w;
		send_byte(lines[7:0], 1, 1);
		send_byte(lines[15:8]);
		for (int line = 0; line < lines; line++) begin
			if (cut && $urandom_range(0, 19) == 0)
				return;
			if ($urandom_range(0, 3) == 0) begin
				sk = $urandom_range(0, 15) == 0 ? 32768 : 65536 - $urandom_range(1, 3);
				send_byte(sk[7:0]);
				send_byte(sk[15:8]);
			end
			p = $urandom_range(0, 3);
			send_byte(8'(p));
			send_byte(0);
			repeat (p) begin
				send_byte(8'($urandom_range(0, 7) == 0 ? 255 :
					$urandom_range(0, w > 255 ? 255 : w)));
				r = $urandom_range(0, 9);
				if (r < 5) begin
					n = $urandom_range(1, r == 0 ? 128 : 6);
					send_byte(8'(256 - n));
					send_pixel();
				end else if (r < 9) begin
					n = $urandom_range(1, 4);
					send_byte(8'(n));
					repeat (n) send_pixel();
				end else
					send_byte(0);
			end
		end
	endtask

	task automatic noise_bytes();
		repeat ($urandom_range(1, 12))
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 6) == 0,
				1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed();
		set_frame(4, 2);
		// run chunk: repeat, zero count, literal, then a run past the frame end
		send_byte(8'hFF, 1, 0);
		send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFE); send_pixel(); send_pixel();
		send_byte(8'h00);
		send_byte(8'h7F); send_byte(8'hFF); send_byte(8'h00);
		send_byte(8'hAA); // after chunk end, ignored
		// delta chunk with no lines gives only the end marker
		send_byte(8'h00, 1, 1); send_byte(8'h00);
		// delta: skip one line, 128-pixel repeat, then empty last line
		send_byte(8'h02, 1, 1); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'h01); send_byte(8'h00);
		send_byte(8'h01); send_byte(8'h80); send_byte(8'h55); send_byte(8'hAA);
		send_byte(8'h00); send_byte(8'h00);
		// restart mid-chunk, then row saturation by a huge skip word
		send_byte(8'h00, 1, 0); send_byte(8'h03);
		send_byte(8'h01, 1, 1); send_byte(8'h00);
		send_byte(8'h00); send_byte(8'h80);
		send_byte(8'h01); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h01); send_pixel();
	endtask

	task automatic test_extreme_sizes();
		set_frame(1024, 1);
		// full-width line from long repeats keeps the item count low
		send_byte(8'h00, 1, 0);
		repeat (8) begin
			send_byte(8'd127);
			send_pixel();
		end
		send_byte(8'd8);
		send_pixel();
		set_frame(1024, 1024);
		repeat (3) lc_chunk($urandom_range(1, 4), 0);
		set_frame(1, 1);
		repeat (3) brun_chunk(0);
		lc_chunk(3, 0);
	endtask

	task automatic test_random_chunks();
		while (items_sent < 750) begin
			if ($urandom_range(0, 4) == 0)
				set_frame($urandom_range(1, 24), $urandom_range(1, 6));
			if (items_sent > 650)
				calm = 1;
			case ($urandom_range(0, 9))
				0: noise_bytes();
				1, 2, 3, 4: brun_chunk($urandom_range(0, 3) == 0);
				default: lc_chunk($urandom_range(0, 5), $urandom_range(0, 3) == 0);
			endcase
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_extreme_sizes();
		test_random_chunks();
		wait_drained();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side stalls in bursts, none near the end
	initial forever begin
		@(negedge clk);
		if (calm)
			pop = 1;
		else if ($urandom_range(0, 7) == 0) begin
			pop = 0;
			repeat ($urandom_range(1, 13) - 1) @(negedge clk);
		end else
			pop = 1;
	end

	always @(posedge clk) begin
		fill_cmd_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n && pop && !empty) begin
			if (fill_q.size() == 0) begin
				$error("result with nothing expected: index %0d", pixel_index);
				errors++;
			end else begin
				e = fill_q.pop_front();
				if (pixel_index !== e.idx) begin
					$error("pixel_index exp %0d got %0d", e.idx, pixel_index);
					errors++;
				end
				if (pixel_value !== e.val) begin
					$error("pixel_value exp %h got %h", e.val, pixel_value);
					errors++;
				end
				if (run_length !== e.len) begin
					$error("run_length exp %0d got %0d", e.len, run_length);
					errors++;
				end
				if (out_of_frame !== e.oof) begin
					$error("out_of_frame exp %0d got %0d", e.oof, out_of_frame);
					errors++;
				end
				if (chunk_end !== e.last) begin
					$error("chunk_end exp %0d got %0d", e.last, chunk_end);
					errors++;
				end
			end
		end
	end
endmodule
